[hw/rtl/sqvg_pkg.sv]
// Shared constants for the rotated sprite quad vertex generator.
// No dependencies; imported by the top level and its checker.
package sqvg_pkg;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  localparam logic [20:0] ONE_Q20 = 21'd1048576;
  localparam logic [20:0] TRIG_A  = 21'd1647099;
  localparam logic [19:0] TRIG_B  = 20'd672759;
  localparam logic [16:0] TRIG_C  = 17'd74235;
  localparam logic [16:0] ONE_Q15 = 17'd32768;

  localparam logic signed [26:0] POS_MIN = -27'sd8388608;
  localparam logic signed [26:0] POS_MAX = 27'sd8388607;

endpackage

[hw/rtl/sprite_quad_vertex_generator.sv]
// Sprite quad vertex generator: expands one sprite command into four vertices.
// Depends on sqvg_pkg.
//
// One sprite is taken per transfer on the input channel and leaves as four vertex
// transfers, top-left, top-right, bottom-right, bottom-left, one per cycle while the
// output is not stalled; the single vertex output port limits the sustained sprite rate.
// After the input register, six stages evaluate the sine/cosine polynomial and
// rotation products, then two stages sum, round and saturate each corner. Later
// sprites enter while earlier ones are still in flight, and output stall backs up
// through the stages without loss. Angles within one unit of zero are not rotated;
// positions are signed Q16.8 and saturate, texture extents saturate at 65535.
// ANGLE_BITS sets the units per full turn (10 to 20).
module sprite_quad_vertex_generator import sqvg_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] dst_x,
  input  logic signed [23:0] dst_y,
  input  logic        [22:0] dst_w,
  input  logic        [22:0] dst_h,
  input  logic        [15:0] src_u,
  input  logic        [15:0] src_v,
  input  logic        [15:0] src_width,
  input  logic        [15:0] src_height,
  input  logic        [31:0] tint_rgba,
  input  logic signed [15:0] angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] pos_x,
  output logic signed [23:0] pos_y,
  output logic        [15:0] tex_u,
  output logic        [15:0] tex_v,
  output logic        [31:0] vertex_rgba,
  output logic        [1:0]  corner,
  output logic               last
);

  localparam int FRAC_SHIFT = 22 - ANGLE_BITS;

  typedef struct packed {
    logic signed [25:0] cx2;
    logic signed [25:0] cy2;
    logic        [22:0] w;
    logic        [22:0] h;
    logic        [15:0] u0;
    logic        [15:0] u1;
    logic        [15:0] v0;
    logic        [15:0] v1;
    logic        [31:0] rgba;
  } geom_t;

  function automatic logic [16:0] qs_round(input logic [20:0] s20);
    logic [21:0] t;
    logic [16:0] r;
    t = 22'(s20) + 22'd16;
    r = t[21:5];
    if (r > ONE_Q15) r = ONE_Q15;
    return r;
  endfunction

  function automatic logic signed [23:0] sat_pos(input logic signed [26:0] r);
    logic signed [26:0] c;
    c = r;
    if (r < POS_MIN) c = POS_MIN;
    if (r > POS_MAX) c = POS_MAX;
    return c[23:0];
  endfunction

  // stage 0: input register
  logic                  p0_valid;
  logic signed [23:0]    p0_x, p0_y;
  logic [22:0]           p0_w, p0_h;
  logic [15:0]           p0_u0, p0_v0, p0_uw, p0_vh;
  logic [31:0]           p0_rgba;
  logic [ANGLE_BITS-1:0] p0_a;

  // stage 1: x squared
  logic                  p1_valid;
  logic [20:0]           p1_xs, p1_xc, p1_x2s, p1_x2c;
  logic [1:0]            p1_q;
  logic                  p1_rot;
  geom_t                 p1_g;

  // stage 2: inner term
  logic                  p2_valid;
  logic [20:0]           p2_xs, p2_xc, p2_x2s, p2_x2c;
  logic [19:0]           p2_ins, p2_inc;
  logic [1:0]            p2_q;
  logic                  p2_rot;
  geom_t                 p2_g;

  // stage 3: middle term
  logic                  p3_valid;
  logic [20:0]           p3_xs, p3_xc, p3_mids, p3_midc;
  logic [1:0]            p3_q;
  logic                  p3_rot;
  geom_t                 p3_g;

  // stage 4: quarter sine in Q20
  logic                  p4_valid;
  logic [20:0]           p4_s20s, p4_s20c;
  logic [1:0]            p4_q;
  logic                  p4_rot;
  geom_t                 p4_g;

  // stage 5: cos and sin in Q15
  logic                  p5_valid;
  logic signed [16:0]    p5_cs, p5_sn;
  geom_t                 p5_g;

  // expander: rotation products, corner sequence
  logic                  e_valid;
  logic [1:0]            e_corner;
  logic signed [40:0]    e_wc, e_ws, e_hc, e_hs;
  geom_t                 e_g;

  // vertex sum stage
  logic                  v1_valid;
  logic signed [42:0]    v1_nx, v1_ny;
  logic [15:0]           v1_u, v1_v;
  logic [31:0]           v1_rgba;
  logic [1:0]            v1_corner;

  logic adv, e_take, r0, r1, r2, r3, r4, r5;

  assign adv    = !out_valid || !out_stall;
  assign e_take = !e_valid || (adv && e_corner == CORNER_BL);
  assign r5     = !p5_valid || e_take;
  assign r4     = !p4_valid || r5;
  assign r3     = !p3_valid || r4;
  assign r2     = !p2_valid || r3;
  assign r1     = !p1_valid || r2;
  assign r0     = !p0_valid || r1;
  assign in_stall = !r0;

  // stage 0 -> 1
  logic signed [31:0] ang_ext;
  logic [ANGLE_BITS-1:0] a_red;
  logic [20:0] xs_w, xc_w;
  logic [41:0] sq_s, sq_c;
  logic [16:0] su, sv;
  geom_t g0;

  assign ang_ext = 32'(angle);
  assign a_red   = ang_ext[ANGLE_BITS-1:0];

  always_comb begin
    xs_w = 21'({p0_a[ANGLE_BITS-3:0], {FRAC_SHIFT{1'b0}}});
    xc_w = ONE_Q20 - xs_w;
    sq_s = 42'(xs_w) * 42'(xs_w);
    sq_c = 42'(xc_w) * 42'(xc_w);
    su = 17'(p0_u0) + 17'(p0_uw);
    sv = 17'(p0_v0) + 17'(p0_vh);
    g0.cx2  = (26'(p0_x) <<< 1) + $signed(26'({1'b0, p0_w}));
    g0.cy2  = (26'(p0_y) <<< 1) + $signed(26'({1'b0, p0_h}));
    g0.w    = p0_w;
    g0.h    = p0_h;
    g0.u0   = p0_u0;
    g0.v0   = p0_v0;
    g0.u1   = su[16] ? 16'hFFFF : su[15:0];
    g0.v1   = sv[16] ? 16'hFFFF : sv[15:0];
    g0.rgba = p0_rgba;
  end

  // stage 1 -> 2
  logic [37:0] mc_s, mc_c;
  always_comb begin
    mc_s = 38'(p1_x2s) * 38'(TRIG_C);
    mc_c = 38'(p1_x2c) * 38'(TRIG_C);
  end

  // stage 2 -> 3
  logic [40:0] mb_s, mb_c;
  always_comb begin
    mb_s = 41'(p2_x2s) * 41'(p2_ins);
    mb_c = 41'(p2_x2c) * 41'(p2_inc);
  end

  // stage 3 -> 4
  logic [41:0] ma_s, ma_c;
  always_comb begin
    ma_s = 42'(p3_xs) * 42'(p3_mids);
    ma_c = 42'(p3_xc) * 42'(p3_midc);
  end

  // stage 4 -> 5
  logic signed [16:0] s15, c15, cs_w, sn_w;
  always_comb begin
    s15 = $signed(qs_round(p4_s20s));
    c15 = $signed(qs_round(p4_s20c));
    unique case (p4_q)
      2'd0:    begin cs_w = c15;  sn_w = s15;  end
      2'd1:    begin cs_w = -s15; sn_w = c15;  end
      2'd2:    begin cs_w = -c15; sn_w = -s15; end
      default: begin cs_w = s15;  sn_w = -c15; end
    endcase
    if (!p4_rot) begin
      cs_w = $signed(ONE_Q15);
      sn_w = 17'sd0;
    end
  end

  // stage 5 -> expander
  logic signed [23:0] w_s, h_s;
  assign w_s = $signed({1'b0, p5_g.w});
  assign h_s = $signed({1'b0, p5_g.h});

  // expander -> vertex sum
  logic right, bottom;
  logic signed [42:0] cx_sh, cy_sh, t_wc, t_ws, t_hc, t_hs;
  always_comb begin
    right  = (e_corner == CORNER_TR) || (e_corner == CORNER_BR);
    bottom = (e_corner == CORNER_BR) || (e_corner == CORNER_BL);
    cx_sh  = 43'(e_g.cx2) <<< 15;
    cy_sh  = 43'(e_g.cy2) <<< 15;
    t_wc   = right  ? 43'(e_wc) : -43'(e_wc);
    t_ws   = right  ? 43'(e_ws) : -43'(e_ws);
    t_hc   = bottom ? 43'(e_hc) : -43'(e_hc);
    t_hs   = bottom ? 43'(e_hs) : -43'(e_hs);
  end

  // vertex sum -> output
  logic signed [42:0] rx, ry;
  logic signed [26:0] px, py;
  always_comb begin
    rx = v1_nx + 43'sd32768;
    ry = v1_ny + 43'sd32768;
    px = $signed(rx[42:16]);
    py = $signed(ry[42:16]);
  end

  always_ff @(posedge clk) begin
    if (r0 && in_valid) begin
      p0_x    <= dst_x;
      p0_y    <= dst_y;
      p0_w    <= dst_w;
      p0_h    <= dst_h;
      p0_u0   <= src_u;
      p0_v0   <= src_v;
      p0_uw   <= src_width;
      p0_vh   <= src_height;
      p0_rgba <= tint_rgba;
      p0_a    <= a_red;
    end
    if (r1 && p0_valid) begin
      p1_xs  <= xs_w;
      p1_xc  <= xc_w;
      p1_x2s <= sq_s[40:20];
      p1_x2c <= sq_c[40:20];
      p1_q   <= p0_a[ANGLE_BITS-1:ANGLE_BITS-2];
      p1_rot <= !((p0_a == '0) || (p0_a == ANGLE_BITS'(1)) || (p0_a == '1));
      p1_g   <= g0;
    end
    if (r2 && p1_valid) begin
      p2_xs  <= p1_xs;
      p2_xc  <= p1_xc;
      p2_x2s <= p1_x2s;
      p2_x2c <= p1_x2c;
      p2_ins <= TRIG_B - 20'(mc_s[37:20]);
      p2_inc <= TRIG_B - 20'(mc_c[37:20]);
      p2_q   <= p1_q;
      p2_rot <= p1_rot;
      p2_g   <= p1_g;
    end
    if (r3 && p2_valid) begin
      p3_xs   <= p2_xs;
      p3_xc   <= p2_xc;
      p3_mids <= TRIG_A - mb_s[40:20];
      p3_midc <= TRIG_A - mb_c[40:20];
      p3_q    <= p2_q;
      p3_rot  <= p2_rot;
      p3_g    <= p2_g;
    end
    if (r4 && p3_valid) begin
      p4_s20s <= ma_s[40:20];
      p4_s20c <= ma_c[40:20];
      p4_q    <= p3_q;
      p4_rot  <= p3_rot;
      p4_g    <= p3_g;
    end
    if (r5 && p4_valid) begin
      p5_cs <= cs_w;
      p5_sn <= sn_w;
      p5_g  <= p4_g;
    end
    if (e_take && p5_valid) begin
      e_wc <= 41'(w_s) * 41'(p5_cs);
      e_ws <= 41'(w_s) * 41'(p5_sn);
      e_hc <= 41'(h_s) * 41'(p5_cs);
      e_hs <= 41'(h_s) * 41'(p5_sn);
      e_g  <= p5_g;
    end
    if (adv) begin
      v1_nx     <= cx_sh + t_wc - t_hs;
      v1_ny     <= cy_sh + t_ws + t_hc;
      v1_u      <= right  ? e_g.u1 : e_g.u0;
      v1_v      <= bottom ? e_g.v1 : e_g.v0;
      v1_rgba   <= e_g.rgba;
      v1_corner <= e_corner;
      pos_x       <= sat_pos(px);
      pos_y       <= sat_pos(py);
      tex_u       <= v1_u;
      tex_v       <= v1_v;
      vertex_rgba <= v1_rgba;
      corner      <= v1_corner;
      last        <= (v1_corner == CORNER_BL);
    end

    if (rst) begin
      p0_valid  <= 1'b0;
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      p3_valid  <= 1'b0;
      p4_valid  <= 1'b0;
      p5_valid  <= 1'b0;
      e_valid   <= 1'b0;
      e_corner  <= CORNER_TL;
      v1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r0) p0_valid <= in_valid;
      if (r1) p1_valid <= p0_valid;
      if (r2) p2_valid <= p1_valid;
      if (r3) p3_valid <= p2_valid;
      if (r4) p4_valid <= p3_valid;
      if (r5) p5_valid <= p4_valid;
      if (e_take) begin
        e_valid  <= p5_valid;
        e_corner <= CORNER_TL;
      end else if (adv && e_valid) begin
        e_corner <= e_corner + 2'd1;
      end
      if (adv) begin
        v1_valid  <= e_valid;
        out_valid <= v1_valid;
      end
    end
  end

endmodule

[hw/rtl/sqvg_checker.sv]
// Port-level checks for the sprite quad vertex generator, and the bind that attaches them.
// Depends on sqvg_pkg and sprite_quad_vertex_generator.
module sqvg_checker import sqvg_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [23:0] pos_x,
  input logic signed [23:0] pos_y,
  input logic        [15:0] tex_u,
  input logic        [15:0] tex_v,
  input logic        [31:0] vertex_rgba,
  input logic        [1:0]  corner,
  input logic               last
);

  // hold a stalled vertex
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(pos_y)
      && $stable(corner) && $stable(tex_u) && $stable(tex_v))
    else $error("stalled vertex changed");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (corner == CORNER_BL)))
    else $error("last flag does not match corner");

  // the four corners of a sprite follow each transfer without a gap
  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && corner != CORNER_BL
      |=> out_valid && corner == $past(corner) + 2'd1 && $stable(vertex_rgba))
    else $error("corner sequence broken");

  a_tex: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && corner == CORNER_TL
      |=> tex_u >= $past(tex_u) && $stable(tex_v))
    else $error("texture edge out of order");

endmodule

bind sprite_quad_vertex_generator sqvg_checker u_sqvg_checker (.*);
